// ===== hw/rtl/gle_pkg.sv =====
// Shared types and constants for the growable list engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gle_pkg;

  // Field widths of the request and response transfers
  localparam int OP_W  = 2;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic finish;
  } gle_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic shift_needed;
    logic shift_more;
    logic slot_free;
  } gle_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gle_req_if.sv =====
// Request channel of the growable list engine: valid/ready plus payload.
// Depends on gle_pkg for the field widths.
`default_nettype none

interface gle_req_if;
  import gle_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output index, output value, input ready);
  modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gle_rsp_if.sv =====
// Response channel of the growable list engine: valid/ready plus payload.
// Depends on gle_pkg for the field widths.
`default_nettype none

interface gle_rsp_if;
  import gle_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] capacity;

  modport source (output valid, output read_value, output status, output entry_count,
                  output capacity, input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  input capacity, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gle_datapath.sv =====
// Datapath of the growable list engine: entry memory, count, capacity,
// shift pointer and the response register. Depends on gle_pkg, gle_rsp_if.
`default_nettype none

module gle_datapath #(
  parameter int MAX_ENTRIES      = 64,
  parameter int DATA_WIDTH       = 32,
  parameter int INITIAL_CAPACITY = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gle_pkg::gle_cmd_t            cmd,
  output gle_pkg::gle_stat_t           stat,
  input  logic [gle_pkg::OP_W-1:0]     operation,
  input  logic [gle_pkg::IDX_W-1:0]    index,
  input  logic [gle_pkg::VAL_W-1:0]    value,
  gle_rsp_if.source                    response
);
  import gle_pkg::*;

  localparam int MAX_CAP = (MAX_ENTRIES > INITIAL_CAPACITY) ? MAX_ENTRIES : INITIAL_CAPACITY;
  localparam int CW      = $clog2(MAX_CAP + 1);
  localparam int XW      = (CW > IDX_W + 1) ? CW : IDX_W + 1;
  localparam int AW      = $clog2(MAX_ENTRIES);
  localparam int SW      = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

  // Latched request
  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;
  logic [SW-1:0]    val_q;

  // List state
  logic [CW-1:0]    count;
  logic [CW-1:0]    cap;
  logic [XW-1:0]    ptr;
  logic [ST_W-1:0]  st_q;

  // Entry memory
  logic [SW-1:0]    entries [MAX_ENTRIES];
  logic [SW-1:0]    rdata;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [SW-1:0]    wdata;
  logic             mem_re;
  logic [AW-1:0]    raddr;

  // Response register
  logic             out_valid;

  // Decode and checks
  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    count_x;
  logic [XW-1:0]    ptr_inc;
  logic             is_append;
  logic             range_err;
  logic             full;
  logic [CW-1:0]    count_dec;
  logic [CW:0]      grown;
  logic [CW-1:0]    cap_grown;
  logic             cap_half_hit;
  logic [ST_W-1:0]  st_calc;

  assign idx_x     = XW'(idx_q);
  assign count_x   = XW'(count);
  assign ptr_inc   = ptr + XW'(1);
  assign is_append = (op_q == OP_APPEND);
  assign range_err = !is_append && (idx_x >= count_x);
  assign full      = is_append && (count >= CW'(MAX_ENTRIES));
  assign count_dec = count - CW'(1);
  assign grown     = {cap, 1'b0};
  assign cap_grown = (grown > (CW + 1)'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : grown[CW-1:0];
  assign cap_half_hit = (count_dec != '0) && (count_dec == (cap >> 2));

  always_comb begin
    priority if (full) begin
      st_calc = ST_FULL;
    end else if (range_err) begin
      st_calc = ST_RANGE;
    end else begin
      st_calc = ST_DONE;
    end
  end

  // Status to the controller
  assign stat.shift_needed = (op_q == OP_REMOVE) && !range_err && ((idx_x + XW'(1)) < count_x);
  assign stat.shift_more   = ptr_inc < count_x;
  assign stat.slot_free    = !out_valid || response.ready;

  // Select memory write port
  always_comb begin
    mem_we = 1'b0;
    waddr  = count[AW-1:0];
    wdata  = val_q;
    priority if (cmd.exec && is_append && !full) begin
      mem_we = 1'b1;
    end else if (cmd.exec && (op_q == OP_SET) && !range_err) begin
      mem_we = 1'b1;
      waddr  = idx_x[AW-1:0];
    end else if (cmd.shift_wr) begin
      mem_we = 1'b1;
      waddr  = ptr[AW-1:0];
      wdata  = rdata;
    end
  end

  // Select memory read port
  always_comb begin
    mem_re = 1'b0;
    raddr  = idx_x[AW-1:0];
    priority if (cmd.exec && (op_q == OP_GET) && !range_err) begin
      mem_re = 1'b1;
    end else if (cmd.shift_rd) begin
      mem_re = 1'b1;
      raddr  = ptr_inc[AW-1:0];
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= entries[raddr];
    end
  end

  // Capture request, status and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      idx_q <= index;
      val_q <= value[SW-1:0];
    end
    if (cmd.exec) begin
      st_q <= st_calc;
      ptr  <= idx_x;
    end else if (cmd.shift_wr) begin
      ptr <= ptr_inc;
    end
  end

  // Update count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CW'(INITIAL_CAPACITY);
    end else if (cmd.exec) begin
      if (is_append && !full) begin
        count <= count + CW'(1);
        if (count >= cap) begin
          cap <= cap_grown;
        end
      end else if ((op_q == OP_REMOVE) && !range_err) begin
        count <= count_dec;
        if (cap_half_hit) begin
          cap <= cap >> 1;
        end
      end
    end
  end

  // Hold the response until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      response.read_value  <= ((op_q == OP_GET) && (st_q == ST_DONE)) ? VAL_W'(rdata) : '0;
      response.status      <= st_q;
      response.entry_count <= CNT_W'(count);
      response.capacity    <= CNT_W'(cap);
    end
  end

  assign response.valid = out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/gle_controller.sv =====
// Controller of the growable list engine: sequences load, execute,
// the remove shift loop and the response hand-off. Depends on gle_pkg.
`default_nettype none

module gle_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gle_pkg::gle_stat_t  stat,
  output gle_pkg::gle_cmd_t   cmd
);
  import gle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SH_RD  = 3'd2;
  localparam logic [2:0] S_SH_WR  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.shift_needed ? S_SH_RD : S_FINISH;
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = stat.shift_more ? S_SH_RD : S_FINISH;
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/growable_list_engine.sv =====
// Growable list engine: an ordered list of data words with doubling and
// halving capacity. Depends on gle_pkg, gle_req_if, gle_rsp_if,
// gle_controller and gle_datapath.
//
// Usage:
//   request carries one operation (append, get, set, remove) with index
//   and value; response returns read_value, status, entry_count and
//   capacity, one response per request, in order. Both are valid/ready.
//   Append, get, set and any refused operation pass from the request
//   transfer through the execute and finish states to the response
//   register; the next request is taken only back in idle.
//   Remove walks the later entries down through the entry memory, one
//   read and one write per entry, for the entry_count_before - 1 - index
//   entries after the removed one.
//   A finished response waits in the output register while the next
//   request is taken; the engine stalls only when a further response is
//   ready and the receiver still holds off.
//   Reset (synchronous, active high) empties the list, sets capacity to
//   INITIAL_CAPACITY and drops any pending response; entry contents are
//   not cleared, which is harmless as only live positions are ever read.
`default_nettype none

module growable_list_engine #(
  parameter int MAX_ENTRIES      = 64,
  parameter int DATA_WIDTH       = 32,
  parameter int INITIAL_CAPACITY = 4
) (
  input  logic      clk,
  input  logic      rst,
  gle_req_if.sink   request,
  gle_rsp_if.source response
);
  import gle_pkg::*;

  gle_cmd_t  cmd;
  gle_stat_t stat;
  logic      in_ready;

  assign request.ready = in_ready;

  gle_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gle_datapath #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .DATA_WIDTH       (DATA_WIDTH),
    .INITIAL_CAPACITY (INITIAL_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (request.operation),
    .index     (request.index),
    .value     (request.value),
    .response  (response)
  );

endmodule

`default_nettype wire

// ===== tb/tb_growable_list_engine.sv =====
// Self-checking testbench for growable_list_engine: a directed opening, then random
// grow/shrink bursts, with idle gaps on both channels. Depends on gle_pkg, gle_req_if,
// gle_rsp_if and the engine RTL.
`default_nettype none

module tb_growable_list_engine;
  import gle_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int START_ROOM   = 4;
  localparam int RANDOM_ITEMS = 730;

  // One predicted response
  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] capacity;
  } list_outcome_t;

  // Tracks the list contents and holds the responses still owed
  class list_scoreboard;
    logic [VAL_W-1:0] live_words [LIST_DEPTH];
    int               word_count;
    int               room;
    int               mismatches;
    list_outcome_t    owed [$];

    function new();
      word_count = 0;
      room       = START_ROOM;
      mismatches = 0;
    endfunction

    // Apply an accepted request to the tracked list and queue its response
    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic [VAL_W-1:0] val);
      list_outcome_t o;
      int            i;
      o = '0;
      o.status = ST_DONE;
      if (op == OP_APPEND) begin
        if (word_count >= LIST_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          if (word_count >= room) room = (room * 2 > LIST_DEPTH) ? LIST_DEPTH : room * 2;
          live_words[word_count] = val;
          word_count++;
        end
      end else if (int'(idx) >= word_count) begin
        o.status = ST_RANGE;
      end else if (op == OP_GET) begin
        o.read_value = live_words[idx];
      end else if (op == OP_SET) begin
        live_words[idx] = val;
      end else begin
        // close the gap, then halve when the list has thinned to a quarter
        for (i = int'(idx); i + 1 < word_count; i++) live_words[i] = live_words[i + 1];
        word_count--;
        if (word_count > 0 && word_count == room / 4) room = room / 2;
      end
      o.entry_count = word_count[CNT_W-1:0];
      o.capacity    = room[CNT_W-1:0];
      owed.push_back(o);
    endfunction

    task report(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      mismatches++;
    endtask

    // Compare a response transfer with the oldest owed response
    task check_response(list_outcome_t got);
      list_outcome_t want;
      if (owed.size() == 0) begin
        report("unexpected response", got.read_value, '0);
      end else begin
        want = owed.pop_front();
        if (got.read_value !== want.read_value)
          report("read_value", got.read_value, want.read_value);
        if (got.status !== want.status)
          report("status", VAL_W'(got.status), VAL_W'(want.status));
        if (got.entry_count !== want.entry_count)
          report("entry_count", VAL_W'(got.entry_count), VAL_W'(want.entry_count));
        if (got.capacity !== want.capacity)
          report("capacity", VAL_W'(got.capacity), VAL_W'(want.capacity));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 12;
  int   recv_idle_pct = 47;

  gle_req_if req_ch ();
  gle_rsp_if rsp_ch ();

  list_scoreboard sb = new();

  growable_list_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every response transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response({rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count,
                         rsp_ch.capacity});
    if (rst) rsp_ch.ready <= 1'b0;
    else     rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one request, idling first at random, and hold it until the transfer
  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                              logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.index     <= idx;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, idx, val);
  endtask

  // Random request: op mix set by the burst kind, indices mostly inside the list
  task automatic send_random(int burst_kind);
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    int               roll;
    roll = $urandom_range(99);
    case (burst_kind)
      0: begin
        op = (roll < 75) ? OP_APPEND : (roll < 85) ? OP_GET : (roll < 93) ? OP_SET : OP_REMOVE;
      end
      1: begin
        op = (roll < 60) ? OP_REMOVE : (roll < 75) ? OP_GET : (roll < 85) ? OP_SET : OP_APPEND;
      end
      default: begin
        op = OP_W'($urandom_range(3));
      end
    endcase
    if (sb.word_count > 0 && $urandom_range(9) != 0)
      idx = IDX_W'($urandom_range(sb.word_count - 1));
    else
      idx = IDX_W'($urandom_range(LIST_DEPTH - 1));
    roll = $urandom_range(19);
    val  = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
    send_request(op, idx, val);
  endtask

  initial begin
    int burst_kind;
    int burst_left;
    int n;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_APPEND;
    req_ch.index     <= '0;
    req_ch.value     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, growth past the first capacity, extremes, halving
    send_request(OP_GET,    6'd0,  32'h0);
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_SET,    6'd63, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd63, 32'h0000_0000);
    send_request(OP_APPEND, 6'd0,  32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd21, 32'hA5A5_A5A5);
    send_request(OP_APPEND, 6'd42, 32'h5A5A_5A5A);
    send_request(OP_APPEND, 6'd0,  32'h0000_0001);
    send_request(OP_GET,    6'd4,  32'hFFFF_FFFF);
    send_request(OP_GET,    6'd5,  32'h0);
    send_request(OP_SET,    6'd0,  32'hFFFF_FFFF);
    send_request(OP_GET,    6'd0,  32'h0);
    send_request(OP_SET,    6'd4,  32'h0000_0000);
    send_request(OP_REMOVE, 6'd1,  32'h0);
    send_request(OP_REMOVE, 6'd3,  32'h0);
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_GET,    6'd1,  32'h0);
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_GET,    6'd0,  32'h0);
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_APPEND, 6'd0,  32'h1234_5678);
    send_request(OP_APPEND, 6'd0,  32'h8765_4321);
    send_request(OP_APPEND, 6'd0,  32'hDEAD_BEEF);

    // Random bursts; swap the idling sides after a third, then stop idling
    burst_kind = 0;
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 12;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (burst_left == 0) begin
        burst_kind = $urandom_range(2);
        burst_left = $urandom_range(20, 70);
      end
      burst_left--;
      send_random(burst_kind);
    end
    req_ch.valid <= 1'b0;

    // Drain the owed responses, then idle before the final check
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/gle_pkg.sv
hw/rtl/gle_req_if.sv
hw/rtl/gle_rsp_if.sv
hw/rtl/gle_datapath.sv
hw/rtl/gle_controller.sv
hw/rtl/growable_list_engine.sv
tb/tb_growable_list_engine.sv
